// ----- rtl/core/stc_pkg.sv -----
// stc_pkg: shared types, codes and rate tables of the timecode counter
// no dependencies
`default_nettype none

package stc_pkg;

    localparam int unsigned InWidth = 88;
    localparam int unsigned OutWidth = 48;
    localparam logic [2:0] MacLast = 3'd4;
    localparam logic [2:0] DivTopShift = 3'd5;
    localparam logic [22:0] DfFramesPerDay = 23'd2589408;
    localparam logic [17:0] DfFramesPerHour = 18'd107892;
    localparam logic [17:0] DfFramesPerTen = 18'd17982;
    localparam logic [17:0] DfFramesPerMinute = 18'd1798;
    localparam logic [17:0] DfFramesPerSecond = 18'd30;
    localparam logic [4:0] DfAdjust = 5'd2;
    localparam logic [4:0] HourMax = 5'd23;
    localparam logic [5:0] MinSecMax = 6'd59;

    typedef enum logic [1:0] {
        OP_LOAD_TC = 2'd0,
        OP_LOAD_COUNT = 2'd1,
        OP_ADD_WRAP = 2'd2,
        OP_ADD_SAT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FPS_24 = 2'd0,
        FPS_25 = 2'd1,
        FPS_30 = 2'd2,
        FPS_60 = 2'd3
    } fps_t;

    typedef enum logic {
        REG_FPS_SELECT = 1'b0,
        REG_DROP_FRAME = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_WRAP,
        ST_FIX,
        ST_DSETUP,
        ST_DSTEP,
        ST_DEND,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       mac;
        logic [2:0] mac_idx;
        logic       wrap;
        logic       fix;
        logic       div_setup;
        logic       div_step;
        logic [2:0] div_shift;
        logic       div_end;
        logic [1:0] phase;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic wrap_ok;
        logic df_on;
    } status_t;

    function automatic logic [5:0] fps_of(input fps_t sel);
        logic [5:0] r;
        unique case (sel)
            FPS_24:  r = 6'd24;
            FPS_25:  r = 6'd25;
            FPS_30:  r = 6'd30;
            FPS_60:  r = 6'd60;
            default: r = 6'd25;
        endcase
        return r;
    endfunction

    function automatic logic [22:0] fpd_of(input fps_t sel, input logic dfon);
        logic [22:0] r;
        unique case (sel)
            FPS_24:  r = 23'd2073600;
            FPS_25:  r = 23'd2160000;
            FPS_30:  r = 23'd2592000;
            FPS_60:  r = 23'd5184000;
            default: r = 23'd2160000;
        endcase
        return dfon ? DfFramesPerDay : r;
    endfunction

    // weights of hour, ten minutes, unit minutes, second, frame
    function automatic logic [17:0] mac_weight(input logic [2:0] idx, input fps_t sel,
                                               input logic dfon);
        logic [17:0] f;
        logic [17:0] r;
        f = {12'd0, fps_of(sel)};
        case (idx)
            3'd0:    r = dfon ? DfFramesPerHour : 18'(f * 18'd3600);
            3'd1:    r = dfon ? DfFramesPerTen : 18'(f * 18'd600);
            3'd2:    r = dfon ? DfFramesPerMinute : 18'(f * 18'd60);
            3'd3:    r = dfon ? DfFramesPerSecond : f;
            default: r = 18'd1;
        endcase
        return r;
    endfunction

    function automatic logic [17:0] div_divisor(input logic [1:0] phase, input fps_t sel,
                                                input logic dfon);
        logic [17:0] f;
        logic [17:0] r;
        f = {12'd0, fps_of(sel)};
        case (phase)
            2'd0:    r = dfon ? DfFramesPerHour : 18'(f * 18'd3600);
            2'd1:    r = dfon ? DfFramesPerTen : 18'(f * 18'd60);
            2'd2:    r = dfon ? DfFramesPerMinute : f;
            default: r = dfon ? DfFramesPerSecond : f;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] div10(input logic [5:0] m);
        logic [2:0] q;
        q = 3'd0;
        for (int i = 1; i < 6; i++)
        begin
            if (m >= 6'(10 * i))
                q = 3'(i);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stc_ctrl.sv -----
// stc_ctrl: sequencing state machine of the timecode counter
// depends on stc_pkg
`default_nettype none

module stc_ctrl
    import stc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] last_phase;
    logic       out_free;

    assign last_phase = status.df_on ? 2'd3 : 2'd2;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.op == OP_LOAD_TC)
                        state_next = ST_MAC;
                    else if (status.op == OP_ADD_WRAP)
                        state_next = ST_WRAP;
                    else
                        state_next = ST_FIX;
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == MacLast)
                    state_next = ST_FIX;
            end
            ST_WRAP:
            begin
                if (status.wrap_ok)
                    state_next = ST_FIX;
            end
            ST_FIX:    state_next = ST_DSETUP;
            ST_DSETUP: state_next = ST_DSTEP;
            ST_DSTEP:
            begin
                if (cnt_reg == 3'd0)
                    state_next = ST_DEND;
            end
            ST_DEND:   state_next = (phase_reg == last_phase) ? ST_OUT : ST_DSETUP;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:   cnt_next = 3'd0;
            ST_MAC:    cnt_next = cnt_reg + 3'd1;
            ST_FIX:    phase_next = 2'd0;
            ST_DSETUP: cnt_next = DivTopShift;
            ST_DSTEP:  cnt_next = cnt_reg - 3'd1;
            ST_DEND:   phase_next = phase_reg + 2'd1;
            default:   cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.mac_idx = cnt_reg;
        cmd.div_shift = cnt_reg;
        cmd.phase = phase_reg;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            ST_MAC:    cmd.mac = 1'b1;
            ST_WRAP:   cmd.wrap = 1'b1;
            ST_FIX:    cmd.fix = 1'b1;
            ST_DSETUP: cmd.div_setup = 1'b1;
            ST_DSTEP:  cmd.div_step = 1'b1;
            ST_DEND:   cmd.div_end = 1'b1;
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:   cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= 3'd0;
            phase_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stc_datapath.sv -----
// stc_datapath: registers, frame count arithmetic and shared divider
// depends on stc_pkg
`default_nettype none

module stc_datapath
    import stc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  hour,
    input  wire logic [7:0]  minute,
    input  wire logic [7:0]  second,
    input  wire logic [7:0]  frame,
    input  wire logic [23:0] frame_count,
    input  wire logic [23:0] offset,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic [4:0]       out_hour,
    output logic [5:0]       out_minute,
    output logic [5:0]       out_second,
    output logic [5:0]       out_frame,
    output logic [22:0]      count_now,
    output logic             adjusted
);

    fps_t        fps_sel_reg;
    logic        drop_reg;
    logic [22:0] fsm_reg;
    op_t         op_reg;
    logic [4:0]  h_in_reg;
    logic [2:0]  mt_in_reg;
    logic [3:0]  mu_in_reg;
    logic [5:0]  s_in_reg;
    logic [5:0]  f_in_reg;
    logic signed [25:0] sum_reg;
    logic        adj_reg;
    logic [22:0] rem_reg;
    logic [5:0]  q_reg;
    logic        small_reg;
    logic [4:0]  dh_reg;
    logic [5:0]  dm_reg;
    logic [5:0]  ds_reg;
    logic [5:0]  dfr_reg;
    logic [2:0]  ten_reg;
    logic [4:0]  oh_reg;
    logic [5:0]  om_reg, os_reg, of_reg;
    logic [22:0] ocount_reg;
    logic        oadj_reg;

    logic        dfon;
    logic [5:0]  fps;
    logic [22:0] fpd;
    logic signed [25:0] fpd_s;
    logic [4:0]  hc;
    logic [5:0]  mc, sc, fc, fmax, fb;
    logic [2:0]  mt;
    logic [3:0]  mu;
    logic        cadj, bump;
    logic [7:0]  term;
    logic [25:0] prod;
    logic [23:0] dshift;
    logic [17:0] divisor;

    assign dfon = drop_reg && (fps_sel_reg == FPS_30);
    assign fps = fps_of(fps_sel_reg);
    assign fpd = fpd_of(fps_sel_reg, dfon);
    assign fpd_s = $signed({3'd0, fpd});
    assign fmax = fps - 6'd1;

    always_comb
    begin
        hc = (hour > 8'(HourMax)) ? HourMax : hour[4:0];
        mc = (minute > 8'(MinSecMax)) ? MinSecMax : minute[5:0];
        sc = (second > 8'(MinSecMax)) ? MinSecMax : second[5:0];
        fc = (frame > {2'd0, fmax}) ? fmax : frame[5:0];
        cadj = (hour > 8'(HourMax)) || (minute > 8'(MinSecMax))
            || (second > 8'(MinSecMax)) || (frame > {2'd0, fmax});
        mt = div10(mc);
        mu = 4'(mc - 6'(mt) * 6'd10);
        bump = dfon && (sc == 6'd0) && (mu != 4'd0) && (fc < 6'(DfAdjust));
        fb = bump ? 6'(DfAdjust) : fc;
    end

    always_comb
    begin
        case (cmd.mac_idx)
            3'd0:    term = {3'd0, h_in_reg};
            3'd1:    term = {5'd0, mt_in_reg};
            3'd2:    term = {4'd0, mu_in_reg};
            3'd3:    term = {2'd0, s_in_reg};
            default: term = {2'd0, f_in_reg};
        endcase
        prod = {18'd0, term} * {8'd0, mac_weight(cmd.mac_idx, fps_sel_reg, dfon)};
        divisor = div_divisor(cmd.phase, fps_sel_reg, dfon);
        dshift = 24'({6'd0, divisor} << cmd.div_shift);
    end

    assign status.op = op_t'(operation);
    assign status.df_on = dfon;
    assign status.wrap_ok = (sum_reg >= 26'sd0) && (sum_reg < fpd_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_sel_reg <= FPS_25;
            drop_reg <= 1'b0;
            fsm_reg <= 23'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_FPS_SELECT: fps_sel_reg <= fps_t'(cfg_data);
                    REG_DROP_FRAME: drop_reg <= cfg_data[0];
                    default:        drop_reg <= drop_reg;
                endcase
            end
            if (cmd.fix)
            begin
                unique case (op_reg)
                    OP_LOAD_COUNT:
                        fsm_reg <= (sum_reg > $signed(fpd_s - 26'sd1)) ? fpd - 23'd1
                                                                      : sum_reg[22:0];
                    OP_ADD_SAT:
                    begin
                        if (sum_reg < 26'sd0)
                            fsm_reg <= 23'd0;
                        else if (sum_reg >= fpd_s)
                            fsm_reg <= fpd - 23'd1;
                        else
                            fsm_reg <= sum_reg[22:0];
                    end
                    default: fsm_reg <= sum_reg[22:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op_t'(operation);
            h_in_reg <= hc;
            mt_in_reg <= mt;
            mu_in_reg <= mu;
            s_in_reg <= sc;
            f_in_reg <= fb;
            adj_reg <= (op_t'(operation) == OP_LOAD_TC) && (cadj || bump);
            case (op_t'(operation))
                OP_LOAD_TC:    sum_reg <= 26'sd0;
                OP_LOAD_COUNT: sum_reg <= $signed({2'd0, frame_count});
                default:       sum_reg <= $signed({3'd0, fsm_reg})
                                        + $signed({{2{offset[23]}}, offset});
            endcase
        end
        if (cmd.mac)
            sum_reg <= sum_reg + $signed(prod);
        if (cmd.wrap)
        begin
            if (sum_reg < 26'sd0)
                sum_reg <= sum_reg + fpd_s;
            else if (sum_reg >= fpd_s)
                sum_reg <= sum_reg - fpd_s;
        end
        if (cmd.fix)
        begin
            case (op_reg)
                OP_LOAD_COUNT:
                    if (sum_reg > $signed(fpd_s - 26'sd1))
                        adj_reg <= 1'b1;
                OP_ADD_SAT:
                    if (sum_reg < 26'sd0 || sum_reg >= fpd_s)
                        adj_reg <= 1'b1;
                default: adj_reg <= adj_reg;
            endcase
        end
        if (cmd.div_setup)
        begin
            q_reg <= 6'd0;
            small_reg <= 1'b0;
            if (cmd.phase == 2'd0)
                rem_reg <= fsm_reg;
            else if (cmd.phase == 2'd2 && dfon)
            begin
                small_reg <= rem_reg < 23'(DfAdjust);
                if (rem_reg >= 23'(DfAdjust))
                    rem_reg <= rem_reg - 23'(DfAdjust);
            end
        end
        if (cmd.div_step && {1'b0, rem_reg} >= dshift)
        begin
            rem_reg <= 23'({1'b0, rem_reg} - dshift);
            q_reg <= q_reg | 6'(6'd1 << cmd.div_shift);
        end
        if (cmd.div_end)
        begin
            case (cmd.phase)
                2'd0: dh_reg <= q_reg[4:0];
                2'd1:
                begin
                    ten_reg <= q_reg[2:0];
                    dm_reg <= q_reg;
                end
                2'd2:
                begin
                    if (dfon)
                    begin
                        dm_reg <= 6'(ten_reg) * 6'd10 + q_reg;
                        if (!small_reg)
                            rem_reg <= rem_reg + 23'(DfAdjust);
                    end
                    else
                    begin
                        ds_reg <= q_reg;
                        dfr_reg <= rem_reg[5:0];
                    end
                end
                default:
                begin
                    ds_reg <= q_reg;
                    dfr_reg <= rem_reg[5:0];
                end
            endcase
        end
        if (cmd.out_load)
        begin
            oh_reg <= dh_reg;
            om_reg <= dm_reg;
            os_reg <= ds_reg;
            of_reg <= dfr_reg;
            ocount_reg <= fsm_reg;
            oadj_reg <= adj_reg;
        end
    end

    assign out_hour = oh_reg;
    assign out_minute = om_reg;
    assign out_second = os_reg;
    assign out_frame = of_reg;
    assign count_now = ocount_reg;
    assign adjusted = oadj_reg;

endmodule

`default_nettype wire

// ----- rtl/core/smpte_timecode_counter_unit.sv -----
// smpte_timecode_counter_unit: top level of the timecode counter
// depends on stc_pkg, stc_ctrl, stc_datapath
`default_nettype none

// Keeps a frame count since midnight at 24, 25, 30 or 60 fps, with 30 fps
// drop-frame, and per word loads a timecode or count, or adds an offset with
// wrap or saturation; each word gives one result word with the decoded
// hh:mm:ss:ff. One word is worked at a time, in five multiply-add steps for a
// timecode load, up to six reduce steps for a wrapping add, and three or four
// six-step divisions in the shared divider.
// A finished result waits in the output register while the next word enters.
module smpte_timecode_counter_unit
    import stc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [1:0]          cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // operation, hour, minute, second, frame, frame_count, offset, zero pad
    input  wire logic [InWidth-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_hour, out_minute, out_second, out_frame, count_now, adjusted, zero pad
    output logic [OutWidth-1:0]      m_tdata
);

    cmd_t        cmd;
    status_t     status;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute, out_second, out_frame;
    logic [22:0] count_now;
    logic        adjusted;

    assign cfg_ready = 1'b1;

    stc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    stc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (s_tdata[1:0]),
        .hour        (s_tdata[9:2]),
        .minute      (s_tdata[17:10]),
        .second      (s_tdata[25:18]),
        .frame       (s_tdata[33:26]),
        .frame_count (s_tdata[57:34]),
        .offset      (s_tdata[81:58]),
        .cmd         (cmd),
        .status      (status),
        .out_hour    (out_hour),
        .out_minute  (out_minute),
        .out_second  (out_second),
        .out_frame   (out_frame),
        .count_now   (count_now),
        .adjusted    (adjusted)
    );

    assign m_tdata = {1'b0, adjusted, count_now, out_frame, out_second, out_minute, out_hour};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] <= 5'd23 && m_tdata[45:23] < 23'd5184000))
        else $error("decoded result out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !s_tready |=> !m_tvalid || $past(cmd.out_load))
        else $error("result word shown twice");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10:5] != 6'd0 |-> m_tdata[10:5] <= 6'd59)
        else $error("minute out of range");

endmodule

`default_nettype wire

// ----- tb/smpte_timecode_counter_unit_tb.sv -----
// testbench for the timecode counter: directed table then random words, each result
// checked against its table entry or an in-bench predictor of count and decoded hh:mm:ss:ff
// depends on stc_pkg and smpte_timecode_counter_unit
`timescale 1ns / 100ps

module smpte_timecode_counter_unit_tb;
    import stc_pkg::*;

    typedef struct packed {
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [5:0]  fr;
        logic [22:0] cnt;
        logic        adj;
    } tc_res_t;

    typedef struct {
        op_t         op;
        logic [7:0]  hr;
        logic [7:0]  mn;
        logic [7:0]  sc;
        logic [7:0]  fr;
        logic [23:0] cnt;
        logic [23:0] offs;
        logic        known;
        tc_res_t     res;
    } tc_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    reg_idx_t cfg_index;
    logic [1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [InWidth-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OutWidth-1:0] m_tdata;

    fps_t rate_sel;
    logic df_en;
    logic [22:0] tc_count;
    tc_res_t pending_results[$];
    int errors;
    int send_idle;
    int recv_stall;
    int hold_cycles;
    tc_row_t rows[$];

    smpte_timecode_counter_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int rate_fps();
        case (rate_sel)
            FPS_24:  return 24;
            FPS_25:  return 25;
            FPS_30:  return 30;
            default: return 60;
        endcase
    endfunction

    function automatic bit drop_on();
        return df_en && rate_sel == FPS_30;
    endfunction

    function automatic longint day_frames();
        return drop_on() ? 64'd2589408 : 64'd86400 * rate_fps();
    endfunction

    // applies one word to the predicted count and returns its result
    function automatic tc_res_t timecode_next(tc_row_t w);
        tc_res_t r;
        longint fps;
        longint fpd;
        longint h;
        longint m;
        longint s;
        longint f;
        longint c;
        longint rem;
        longint ten;
        longint unit;
        fps = rate_fps();
        fpd = day_frames();
        r.adj = 1'b0;
        if (w.op == OP_LOAD_TC)
        begin
            h = w.hr;
            m = w.mn;
            s = w.sc;
            f = w.fr;
            if (h > 23) begin h = 23; r.adj = 1'b1; end
            if (m > 59) begin m = 59; r.adj = 1'b1; end
            if (s > 59) begin s = 59; r.adj = 1'b1; end
            if (f > fps - 1) begin f = fps - 1; r.adj = 1'b1; end
            if (drop_on())
            begin
                if (s == 0 && m % 10 != 0 && f < 2)
                begin
                    f = 2;
                    r.adj = 1'b1;
                end
                c = f + s * 30 + (m % 10) * 1798 + (m / 10) * 17982 + h * 107892;
            end
            else
                c = f + fps * (s + m * 60 + h * 3600);
        end
        else if (w.op == OP_LOAD_COUNT)
        begin
            c = w.cnt;
            if (c > fpd - 1) begin c = fpd - 1; r.adj = 1'b1; end
        end
        else
        begin
            c = longint'(tc_count) + longint'($signed(w.offs));
            if (w.op == OP_ADD_WRAP)
            begin
                c = c % fpd;
                if (c < 0)
                    c += fpd;
            end
            else if (c < 0) begin c = 0; r.adj = 1'b1; end
            else if (c > fpd - 1) begin c = fpd - 1; r.adj = 1'b1; end
        end
        tc_count = c[22:0];
        c = tc_count;
        if (drop_on())
        begin
            h = c / 107892;
            rem = c % 107892;
            ten = rem / 17982;
            rem = rem % 17982;
            if (rem < 2)
            begin
                unit = 0;
                f = rem;
            end
            else
            begin
                unit = (rem - 2) / 1798;
                f = (rem - 2) % 1798 + 2;
            end
            m = ten * 10 + unit;
            s = f / 30;
            f = f % 30;
        end
        else
        begin
            h = c / (3600 * fps);
            rem = c % (3600 * fps);
            m = rem / (60 * fps);
            rem = rem % (60 * fps);
            s = rem / fps;
            f = rem % fps;
        end
        r.hr = h[4:0];
        r.mn = m[5:0];
        r.sc = s[5:0];
        r.fr = f[5:0];
        r.cnt = tc_count;
        return r;
    endfunction

    function automatic tc_row_t rand_word();
        tc_row_t w;
        w.op = op_t'($urandom_range(0, 3));
        w.hr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
        w.mn = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 59));
        w.sc = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            w.sc = 8'($urandom_range(0, 59));
        w.fr = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 59));
        w.cnt = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5183999));
        case ($urandom_range(0, 3))
            0:       w.offs = 24'($urandom);
            1:       w.offs = 24'($signed($urandom_range(0, 4000)) - 2000);
            default: w.offs = 24'($signed($urandom_range(0, 200000)) - 100000);
        endcase
        w.known = 1'b0;
        return w;
    endfunction

    task automatic cfg_write(reg_idx_t idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_FPS_SELECT)
            rate_sel = fps_t'(val);
        else
            df_en = val[0];
    endtask

    task automatic send_word(tc_row_t w);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w.offs, w.cnt, w.fr, w.sc, w.mn, w.hr, w.op};
        do
            @(posedge clk);
        while (!s_tready);
        if (w.known)
            pending_results.push_back(w.res);
        else
            pending_results.push_back(timecode_next(w));
        if (w.known)
            tc_count = w.res.cnt;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_word(rand_word());
    endtask

    always @(posedge clk)
    begin
        tc_res_t got;
        tc_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hr = m_tdata[4:0];
            got.mn = m_tdata[10:5];
            got.sc = m_tdata[16:11];
            got.fr = m_tdata[22:17];
            got.cnt = m_tdata[45:23];
            got.adj = m_tdata[46];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    $display("%0t: mismatch expected h%0d m%0d s%0d f%0d c%0d a%0d",
                        $time, exp_r.hr, exp_r.mn, exp_r.sc, exp_r.fr, exp_r.cnt, exp_r.adj);
                    $display("%0t:          actual h%0d m%0d s%0d f%0d c%0d a%0d",
                        $time, got.hr, got.mn, got.sc, got.fr, got.cnt, got.adj);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
    end

    function automatic tc_row_t mk(op_t op, int h, int m, int s, int f, int c, int o);
        tc_row_t w;
        w.op = op;
        w.hr = 8'(h);
        w.mn = 8'(m);
        w.sc = 8'(s);
        w.fr = 8'(f);
        w.cnt = 24'(c);
        w.offs = 24'(o);
        w.known = 1'b0;
        return w;
    endfunction

    function automatic tc_row_t mk_known(tc_row_t w, int h, int m, int s, int f, int c, bit a);
        w.known = 1'b1;
        w.res = '{5'(h), 6'(m), 6'(s), 6'(f), 23'(c), a};
        return w;
    endfunction

    initial
    begin
        errors = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_cycles = 0;
        rate_sel = FPS_25;
        df_en = 1'b0;
        tc_count = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FPS_SELECT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset rate of 25 fps
        rows.push_back(mk_known(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_known(mk(OP_LOAD_TC, 255, 255, 255, 255, 0, 0),
            23, 59, 59, 24, 2159999, 1));
        rows.push_back(mk_known(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 1), 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_known(mk(OP_ADD_SAT, 0, 0, 0, 0, 0, -1), 0, 0, 0, 0, 0, 1));
        rows.push_back(mk_known(mk(OP_LOAD_COUNT, 0, 0, 0, 0, 24'hffffff, 0),
            23, 59, 59, 24, 2159999, 1));
        rows.push_back(mk_known(mk(OP_ADD_SAT, 0, 0, 0, 0, 0, 8388607),
            23, 59, 59, 24, 2159999, 1));
        rows.push_back(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, -8388608));
        rows.push_back(mk(OP_LOAD_TC, 12, 34, 56, 7, 0, 0));
        rows.push_back(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 8388607));
        foreach (rows[i])
            send_word(rows[i]);
        drain();

        // drop-frame rows
        cfg_write(REG_FPS_SELECT, FPS_30);
        cfg_write(REG_DROP_FRAME, 1'b1);
        rows.delete();
        rows.push_back(mk_known(mk(OP_LOAD_TC, 0, 1, 0, 0, 0, 0), 0, 1, 0, 2, 1800, 1));
        rows.push_back(mk_known(mk(OP_LOAD_TC, 0, 10, 0, 0, 0, 0), 0, 10, 0, 0, 17982, 0));
        rows.push_back(mk(OP_LOAD_TC, 1, 59, 0, 1, 0, 0));
        rows.push_back(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, -1));
        rows.push_back(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 1));
        rows.push_back(mk_known(mk(OP_LOAD_COUNT, 0, 0, 0, 0, 24'hffffff, 0),
            23, 59, 59, 29, 2589407, 1));
        rows.push_back(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 3));
        foreach (rows[i])
            send_word(rows[i]);
        drain();

        // 60 fps with a stale count from drop-frame left in place
        cfg_write(REG_FPS_SELECT, FPS_60);
        rows.delete();
        rows.push_back(mk(OP_ADD_SAT, 0, 0, 0, 0, 0, 5));
        rows.push_back(mk_known(mk(OP_LOAD_COUNT, 0, 0, 0, 0, 5183999, 0),
            23, 59, 59, 59, 5183999, 0));
        foreach (rows[i])
            send_word(rows[i]);
        drain();
        cfg_write(REG_FPS_SELECT, FPS_24);
        send_word(mk(OP_ADD_WRAP, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_LOAD_TC, 23, 59, 59, 23, 0, 0));
        drain();

        // random phases over rates and idling patterns
        for (int p = 0; p < 16; p++)
        begin
            cfg_write(REG_FPS_SELECT, 2'(p % 4));
            cfg_write(REG_DROP_FRAME, 1'(p / 4 % 2));
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                3: begin send_idle = 22; recv_stall = 22; end
            endcase
            if (p == 5)
                hold_cycles = 600;
            run_random(p >= 8 && p % 4 == 2 ? 110 : 90);
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        cfg_write(REG_FPS_SELECT, FPS_30);
        cfg_write(REG_DROP_FRAME, 1'b1);
        run_random(90);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/stc_pkg.sv
rtl/core/stc_ctrl.sv
rtl/core/stc_datapath.sv
rtl/core/smpte_timecode_counter_unit.sv
tb/smpte_timecode_counter_unit_tb.sv
